// File: rtl/core/lftp_pkg.sv
// Shared constants, operation codes and entry type for the latency fault table picker.
`timescale 1ns / 1ps

package lftp_pkg;

    // Table geometry.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = IDX_W + 1;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int ID_W     = 4;
    localparam int LAT_W    = 24;
    localparam int PEN_W    = 24;
    localparam int NOW_W    = 40;
    localparam int DL_W     = 41;
    localparam int CTR_W    = 32;
    localparam int STEP_W   = $clog2(CTR_W);

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd3;

    // One stored table entry.
    typedef struct packed {
        logic [LAT_W-1:0] latency;
        logic [DL_W-1:0]  deadline;
    } t_entry;

endpackage

// File: rtl/core/latency_fault_table_picker.sv
// Top level of the latency fault table picker: entry table, pick ranking sequencer and stream ports.
`timescale 1ns / 1ps

// Update and remove go straight to S_OUT to register their result; a query passes S_QUERY first.
// A pick counts the present entries in S_COUNT, runs the shared one-bit-per-cycle remainder
// unit in S_DIV, then ranks candidates through S_NEXTI, S_LOADI and S_SCAN in the single
// ranking comparator, which reads one table entry per cycle, and registers the result in S_OUT.
// Throughput: one word at a time; the next word is taken as soon as the result is registered.
// Reset (synchronous, active low) clears all present marks, the pick counter and the output valid.
module latency_fault_table_picker
    import lftp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input word, from bit 0: op[1:0], entry_index[5:2], latency_ms[29:6],
    // penalty_ms[53:30], now_ms[93:54], zero padding[95:94].
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result word, from bit 0: available[0], pick_found[1], picked_index[5:2],
    // zero padding[7:6].
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QUERY = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_NEXTI = 3'd4;
    localparam logic [2:0] S_LOADI = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // Input word fields.
    logic [OP_W-1:0]  w_op;
    logic [ID_W-1:0]  w_id;
    logic [LAT_W-1:0] w_lat;
    logic [PEN_W-1:0] w_pen;
    logic [NOW_W-1:0] w_now;
    logic             w_in_table;
    logic             w_s_acc;

    assign w_op       = s_tdata[1:0];
    assign w_id       = s_tdata[5:2];
    assign w_lat      = s_tdata[29:6];
    assign w_pen      = s_tdata[53:30];
    assign w_now      = s_tdata[93:54];
    assign w_in_table = (32'(w_id) < ENTRIES);
    assign w_s_acc    = s_tvalid && s_tready;

    // Control registers.
    logic [2:0]         r_state, n_state;
    logic [ENTRIES-1:0] r_present, n_present;
    logic [CTR_W-1:0]   r_pick_cnt, n_pick_cnt;
    logic               r_out_v, n_out_v;

    // Datapath registers.
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic              r_in_table, n_in_table;
    logic [NOW_W-1:0]  r_now, n_now;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [IDX_W-1:0]  r_only, n_only;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CTR_W-1:0]  r_div_sh, n_div_sh;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_rank, n_rank;
    logic              r_cmp_v, n_cmp_v;
    logic [CNT_W-1:0]  r_cmp_j, n_cmp_j;
    logic [LAT_W-1:0]  r_cand_lat, n_cand_lat;
    logic [DL_W-1:0]   r_cand_dl, n_cand_dl;
    logic              r_cand_free, n_cand_free;
    logic              r_res_avail, n_res_avail;
    logic              r_res_found, n_res_found;
    logic [ID_W-1:0]   r_res_idx, n_res_idx;
    logic [M_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    // Entry memory: one write port, one registered read port.
    t_entry           mem [ENTRIES];
    t_entry           r_rd_data;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_wr_data;

    assign w_wr_data.latency  = w_lat;
    assign w_wr_data.deadline = DL_W'({1'b0, w_now} + {{(DL_W-PEN_W){1'b0}}, w_pen});
    assign w_mem_we = (r_state == S_IDLE) && w_s_acc && (w_op == OP_UPDATE) && w_in_table;

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_rd_addr = IDX_W'(w_id);
            S_SCAN:  w_rd_addr = r_j[IDX_W-1:0];
            default: w_rd_addr = r_i[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[IDX_W'(w_id)] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    // Shared ranking comparator: does the entry just read rank ahead of the candidate?
    logic w_cmp_free;
    logic w_ahead;

    assign w_cmp_free = ({1'b0, r_now} >= r_rd_data.deadline);

    always_comb begin
        if (w_cmp_free != r_cand_free) begin
            w_ahead = w_cmp_free;
        end else if (r_rd_data.latency != r_cand_lat) begin
            w_ahead = (r_rd_data.latency < r_cand_lat);
        end else if (r_rd_data.deadline != r_cand_dl) begin
            w_ahead = (r_rd_data.deadline < r_cand_dl);
        end else begin
            w_ahead = (r_cmp_j < r_i);
        end
    end

    // Shared remainder unit: restoring step, one dividend bit per cycle.
    logic [IDX_W-1:0] w_div;
    logic [CNT_W:0]   w_trial;
    logic             w_fits;

    assign w_div   = r_n[CNT_W-1:1];
    assign w_trial = {r_rem, r_div_sh[CTR_W-1]};
    assign w_fits  = (w_trial >= (CNT_W+1)'(w_div));

    logic w_m_acc;
    assign w_m_acc = r_out_v && m_tready;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_present   = r_present;
        n_pick_cnt  = r_pick_cnt;
        n_out_v     = r_out_v;
        n_addr      = r_addr;
        n_in_table  = r_in_table;
        n_now       = r_now;
        n_j         = r_j;
        n_i         = r_i;
        n_n         = r_n;
        n_only      = r_only;
        n_rem       = r_rem;
        n_div_sh    = r_div_sh;
        n_step      = r_step;
        n_rank      = r_rank;
        n_cmp_v     = r_cmp_v;
        n_cmp_j     = r_cmp_j;
        n_cand_lat  = r_cand_lat;
        n_cand_dl   = r_cand_dl;
        n_cand_free = r_cand_free;
        n_res_avail = r_res_avail;
        n_res_found = r_res_found;
        n_res_idx   = r_res_idx;
        n_m_tdata   = r_m_tdata;

        if (w_m_acc) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_addr      = IDX_W'(w_id);
                    n_in_table  = w_in_table;
                    n_now       = w_now;
                    n_res_avail = 1'b0;
                    n_res_found = 1'b0;
                    n_res_idx   = '0;
                    unique case (w_op)
                        OP_UPDATE: begin
                            if (w_in_table) begin
                                n_present[IDX_W'(w_id)] = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        OP_QUERY: begin
                            n_state = S_QUERY;
                        end
                        OP_REMOVE: begin
                            if (w_in_table) begin
                                n_present[IDX_W'(w_id)] = 1'b0;
                            end
                            n_state = S_OUT;
                        end
                        OP_PICK: begin
                            n_j     = '0;
                            n_n     = '0;
                            n_only  = '0;
                            n_state = S_COUNT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_QUERY: begin
                n_res_avail = !r_in_table || !r_present[r_addr]
                              || ({1'b0, r_now} >= r_rd_data.deadline);
                n_state     = S_OUT;
            end
            S_COUNT: begin
                if (r_j < CNT_W'(ENTRIES)) begin
                    if (r_present[r_j[IDX_W-1:0]]) begin
                        n_n    = r_n + 1'b1;
                        n_only = r_j[IDX_W-1:0];
                    end
                    n_j = r_j + 1'b1;
                end else if (r_n == '0) begin
                    n_state = S_OUT;
                end else if (r_n == CNT_W'(1)) begin
                    n_res_found = 1'b1;
                    n_res_idx   = ID_W'(r_only);
                    n_state     = S_OUT;
                end else begin
                    n_rem      = '0;
                    n_div_sh   = r_pick_cnt;
                    n_step     = '0;
                    n_pick_cnt = r_pick_cnt + 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                n_rem    = w_fits ? CNT_W'(w_trial - (CNT_W+1)'(w_div)) : CNT_W'(w_trial);
                n_div_sh = {r_div_sh[CTR_W-2:0], 1'b0};
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(CTR_W - 1)) begin
                    n_i     = '0;
                    n_state = S_NEXTI;
                end
            end
            S_NEXTI: begin
                if (r_i >= CNT_W'(ENTRIES)) begin
                    n_state = S_OUT;
                end else if (r_present[r_i[IDX_W-1:0]]) begin
                    n_state = S_LOADI;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_LOADI: begin
                n_cand_lat  = r_rd_data.latency;
                n_cand_dl   = r_rd_data.deadline;
                n_cand_free = ({1'b0, r_now} >= r_rd_data.deadline);
                n_j         = '0;
                n_rank      = '0;
                n_cmp_v     = 1'b0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (r_j < CNT_W'(ENTRIES)) begin
                    n_cmp_v = 1'b1;
                    n_cmp_j = r_j;
                    n_j     = r_j + 1'b1;
                end else begin
                    n_cmp_v = 1'b0;
                end
                if (r_cmp_v && (r_cmp_j != r_i) && r_present[r_cmp_j[IDX_W-1:0]]
                        && w_ahead) begin
                    n_rank = r_rank + 1'b1;
                end
                if ((r_j >= CNT_W'(ENTRIES)) && !r_cmp_v) begin
                    if (r_rank == r_rem) begin
                        n_res_found = 1'b1;
                        n_res_idx   = ID_W'(r_i[IDX_W-1:0]);
                        n_state     = S_OUT;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_NEXTI;
                    end
                end
            end
            S_OUT: begin
                // The output register is free, or is being emptied this cycle.
                if (!r_out_v || m_tready) begin
                    n_out_v   = 1'b1;
                    n_m_tdata = {2'b00, r_res_idx, r_res_found, r_res_avail};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_present  <= '0;
            r_pick_cnt <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_present  <= n_present;
            r_pick_cnt <= n_pick_cnt;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_in_table  <= n_in_table;
        r_now       <= n_now;
        r_j         <= n_j;
        r_i         <= n_i;
        r_n         <= n_n;
        r_only      <= n_only;
        r_rem       <= n_rem;
        r_div_sh    <= n_div_sh;
        r_step      <= n_step;
        r_rank      <= n_rank;
        r_cmp_v     <= n_cmp_v;
        r_cmp_j     <= n_cmp_j;
        r_cand_lat  <= n_cand_lat;
        r_cand_dl   <= n_cand_dl;
        r_cand_free <= n_cand_free;
        r_res_avail <= n_res_avail;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
        r_m_tdata   <= n_m_tdata;
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_v;
    assign m_tdata  = r_m_tdata;

    // The partial remainder always stays below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < CNT_W'(w_div)))
        else $error("remainder reached the divisor");

    // A candidate can never have as many entries ahead of it as are present.
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rank < r_n))
        else $error("rank exceeds present count");

    // The scan index never runs past the table.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j <= CNT_W'(ENTRIES)))
        else $error("scan index past table");

    // An update of an entry inside the table marks it present.
    a_update_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (w_op == OP_UPDATE) && w_in_table) |=> r_present[r_addr])
        else $error("update did not mark entry present");

endmodule

// File: tb/tb_latency_fault_table_picker.sv
// Self-checking testbench for the latency fault table picker stream block.
`timescale 1ns / 1ps

module tb_latency_fault_table_picker;
    import lftp_pkg::*;

    // Worst pick: count pass, remainder unit and a full ranking sweep, plus some margin.
    localparam int PICK_CYCLES = ENTRIES + 1 + CTR_W + ENTRIES * (ENTRIES + 4);
    localparam int TAIL_CYCLES = PICK_CYCLES + 64;
    // Far above the slowest correct run: every word a pick, each waiting out long stalls.
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_PRINTED = 40;

    // One expected result word, split into its fields.
    typedef struct packed {
        logic            available;
        logic            pick_found;
        logic [ID_W-1:0] picked_index;
    } t_lookup_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // From bit 0: op, entry_index, latency_ms, penalty_ms, now_ms, zero padding.
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // From bit 0: available, pick_found, picked_index, zero padding.
    logic [M_TDATA_W-1:0] m_tdata;

    // Our own copy of the table, kept in step with every accepted word.
    logic                 slot_live     [ENTRIES];
    logic [LAT_W-1:0]     slot_latency  [ENTRIES];
    logic [DL_W-1:0]      slot_deadline [ENTRIES];
    logic [CTR_W-1:0]     pick_turn;

    t_lookup_result       expected_q[$];

    // Shared controls for the two sides of the stream.
    bit                   idle_on = 1'b1;
    int                   stall_request = 0;
    int                   stall_left = 0;

    int                   mismatches = 0;
    int                   results_seen = 0;
    int                   words_by_op[4];
    int                   picks_found = 0;
    int                   cycle_count = 0;

    latency_fault_table_picker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run guard: a hang anywhere ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_q.size());
            $display("latency_fault_table_picker regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    function automatic void clear_table();
        for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i]     = 1'b0;
            slot_latency[i]  = '0;
            slot_deadline[i] = '0;
        end
        pick_turn = '0;
    endfunction

    // An entry is free once the current time has reached its deadline.
    function automatic logic slot_free(int idx, logic [NOW_W-1:0] now);
        return {1'b0, now} >= slot_deadline[idx];
    endfunction

    // True when entry a sorts ahead of entry b: free first, then lower latency,
    // then earlier deadline, then lower id.
    function automatic logic ranks_ahead(int a, int b, logic [NOW_W-1:0] now);
        logic free_a;
        logic free_b;
        free_a = slot_free(a, now);
        free_b = slot_free(b, now);
        if (free_a != free_b)
            return free_a;
        if (slot_latency[a] != slot_latency[b])
            return slot_latency[a] < slot_latency[b];
        if (slot_deadline[a] != slot_deadline[b])
            return slot_deadline[a] < slot_deadline[b];
        return a < b;
    endfunction

    // Applies one word to the table copy and returns the result it must produce.
    function automatic t_lookup_result apply_to_table(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                                      logic [LAT_W-1:0] lat,
                                                      logic [PEN_W-1:0] pen,
                                                      logic [NOW_W-1:0] now);
        t_lookup_result res;
        int             live_count;
        int             only_id;
        int             rank;
        logic [CTR_W-1:0] half;
        logic [CTR_W-1:0] target;
        logic           done;
        res = '0;
        live_count = 0;
        only_id = 0;
        done = 1'b0;
        case (op)
            OP_UPDATE: begin
                if (id < ENTRIES) begin
                    slot_live[id]     = 1'b1;
                    slot_latency[id]  = lat;
                    slot_deadline[id] = {1'b0, now} + {{(DL_W - PEN_W){1'b0}}, pen};
                end
            end
            OP_QUERY: begin
                if (id >= ENTRIES || !slot_live[id] || slot_free(id, now))
                    res.available = 1'b1;
            end
            OP_REMOVE: begin
                if (id < ENTRIES) begin
                    slot_live[id]     = 1'b0;
                    slot_latency[id]  = '0;
                    slot_deadline[id] = '0;
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_live[i]) begin
                        live_count++;
                        only_id = i;
                    end
                end
                if (live_count == 1) begin
                    res.pick_found   = 1'b1;
                    res.picked_index = only_id[ID_W-1:0];
                end else if (live_count > 1) begin
                    half   = CTR_W'(live_count / 2);
                    target = pick_turn % half;
                    pick_turn = pick_turn + 1'b1;
                    for (int i = 0; i < ENTRIES && !done; i++) begin
                        if (slot_live[i]) begin
                            rank = 0;
                            for (int j = 0; j < ENTRIES; j++) begin
                                if (j != i && slot_live[j] && ranks_ahead(j, i, now))
                                    rank++;
                            end
                            if (rank == target) begin
                                res.pick_found   = 1'b1;
                                res.picked_index = i[ID_W-1:0];
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stream sides
    // ------------------------------------------------------------------

    // Offers one word, with a random gap ahead of it while idling is on, and
    // records its expected result once the block takes it.
    task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [LAT_W-1:0] lat,
                             logic [PEN_W-1:0] pen, logic [NOW_W-1:0] now);
        int gap;
        t_lookup_result res;
        if (idle_on && $urandom_range(99) < 24) begin
            // Mostly short gaps, sometimes long enough to land inside a pick.
            gap = ($urandom_range(9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, now, pen, lat, id, op};
        do
            @(posedge i_clk);
        while (!s_tready);
        res = apply_to_table(op, id, lat, pen, now);
        expected_q.insert(expected_q.size(), res);
        words_by_op[op]++;
        if (res.pick_found)
            picks_found++;
    endtask

    // Drops the valid and waits for every outstanding result.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: a long hold-off when one is requested, random stalls otherwise.
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(99) < 24) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Every accepted result word is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_lookup_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result word", 32'(m_tdata), 32'd0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[0] !== want.available)
                    report_mismatch("available", 32'(m_tdata[0]), 32'(want.available));
                if (m_tdata[1] !== want.pick_found)
                    report_mismatch("pick_found", 32'(m_tdata[1]), 32'(want.pick_found));
                if (m_tdata[5:2] !== want.picked_index)
                    report_mismatch("picked_index", 32'(m_tdata[5:2]),
                                    32'(want.picked_index));
                if (m_tdata[7:6] !== 2'b00)
                    report_mismatch("result padding", 32'(m_tdata[7:6]), 32'd0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    function automatic logic [NOW_W-1:0] random_ms();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[NOW_W-1:0];
    endfunction

    function automatic logic [LAT_W-1:0] random_24();
        logic [31:0] raw;
        raw = $urandom;
        return raw[LAT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pick, query and remove on a table with nothing in it.
    task automatic test_empty_table();
        send_word(OP_PICK,   4'd0, '0, '0, '0);
        send_word(OP_QUERY,  4'd0, '0, '0, '0);
        send_word(OP_REMOVE, 4'd7, '0, '0, '0);
    endtask

    // Field extremes, a deadline past the 40-bit time range, the single-entry pick
    // and a query exactly at the deadline.
    task automatic test_single_entry();
        send_word(OP_UPDATE, 4'd15, '1, '1, '1);
        send_word(OP_QUERY,  4'd15, '0, '0, '1);
        send_word(OP_PICK,   4'd0,  '0, '0, '1);
        send_word(OP_QUERY,  4'd15, '0, '0, '0);
        send_word(OP_UPDATE, 4'd3,  '0, '0, '0);
        send_word(OP_UPDATE, 4'd5,  '0, 24'd10, 40'd100);
        send_word(OP_QUERY,  4'd5,  '0, '0, 40'd109);
        send_word(OP_QUERY,  4'd5,  '0, '0, 40'd110);
    endtask

    // Ties on latency and deadline down to the id, then the pick rotation and removes.
    task automatic test_ranking_ties();
        send_word(OP_PICK,   4'd0, '0, '0, 40'd110);
        send_word(OP_UPDATE, 4'd9, '0, '0, 40'd110);
        send_word(OP_UPDATE, 4'd1, '0, '0, 40'd0);
        send_word(OP_PICK,   4'd0, '0, '0, 40'd110);
        send_word(OP_PICK,   4'd0, '0, '0, 40'd110);
        send_word(OP_PICK,   4'd0, '0, '0, 40'd110);
        send_word(OP_REMOVE, 4'd15, '0, '0, 40'd110);
        send_word(OP_REMOVE, 4'd3, '0, '0, 40'd110);
        send_word(OP_PICK,   4'd0, '0, '0, 40'd110);
        send_word(OP_REMOVE, 4'd1, '0, '0, 40'd110);
        send_word(OP_REMOVE, 4'd5, '0, '0, 40'd110);
        send_word(OP_PICK,   4'd0, '0, '0, 40'd110);
    endtask

    // Random traffic around a running time, with small latencies and penalties most
    // of the time so that entries tie and deadlines cross the current time.
    task automatic test_random_traffic(int words, logic [NOW_W-1:0] start_ms, int remove_pct);
        logic [NOW_W-1:0] clock_ms;
        logic [NOW_W-1:0] now;
        logic [OP_W-1:0]  op;
        logic [LAT_W-1:0] lat;
        logic [PEN_W-1:0] pen;
        int               roll;
        clock_ms = start_ms;
        for (int k = 0; k < words; k++) begin
            roll = $urandom_range(99);
            if (roll < 35)
                op = OP_UPDATE;
            else if (roll < 60)
                op = OP_QUERY;
            else if (roll < 60 + remove_pct)
                op = OP_REMOVE;
            else
                op = OP_PICK;
            clock_ms = clock_ms + NOW_W'($urandom_range(0, 40));
            case ($urandom_range(19))
                0:       now = random_ms();
                1:       now = '1;
                default: now = clock_ms;
            endcase
            lat = ($urandom_range(3) == 0) ? random_24() : LAT_W'($urandom_range(0, 7));
            pen = ($urandom_range(4) == 0) ? random_24() : PEN_W'($urandom_range(0, 300));
            send_word(op, ID_W'($urandom_range(ENTRIES - 1)), lat, pen, now);
        end
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the
    // block keeps its result and stops taking input.
    task automatic test_output_hold();
        stall_request = 600;
        test_random_traffic(40, 40'd50000, 10);
    endtask

    // The sender stops mid-traffic until every result is back, then resumes.
    task automatic test_sender_pause();
        test_random_traffic(100, 40'd90000, 10);
        wait_drained();
        test_random_traffic(100, 40'd95000, 10);
    endtask

    initial begin
        clear_table();
        for (int k = 0; k < 4; k++)
            words_by_op[k] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_single_entry();
        test_ranking_ties();
        test_random_traffic(550, 40'd1000, 10);
        // A steady stretch with no idling on either side, crossing the top of time.
        idle_on = 1'b0;
        test_random_traffic(250, 40'hFF_FFFF_F000, 10);
        idle_on = 1'b1;
        test_output_hold();
        test_sender_pause();
        // Heavier removes keep the table small, where the pick rotation is short.
        test_random_traffic(400, random_ms(), 25);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d updates, %0d queries, %0d removes and %0d picks (%0d found).",
                 words_by_op[OP_UPDATE], words_by_op[OP_QUERY], words_by_op[OP_REMOVE],
                 words_by_op[OP_PICK], picks_found);
        $display("Checked %0d result words in %0d cycles, %0d mismatches.",
                 results_seen, cycle_count, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("latency_fault_table_picker regression: pass");
        end else begin
            $display("latency_fault_table_picker regression: fail");
        end
        $finish;
    end

endmodule

// File: latency_fault_table_picker.f
rtl/core/lftp_pkg.sv
rtl/core/latency_fault_table_picker.sv
tb/tb_latency_fault_table_picker.sv
